// ----- rtl/core/tcp_connection_state_engine_assert.svh -----
// Assertion macros for the TCP connection state engine checker.
// Needs signals named clock and reset where the macros are used.
`ifndef TCP_CONNECTION_STATE_ENGINE_ASSERT_SVH
`define TCP_CONNECTION_STATE_ENGINE_ASSERT_SVH

// same-cycle implication
`define TCSE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/tcse_pkg.sv -----
// Types and constants for the TCP connection state engine.
// No dependencies; used by the channel interface users, the engine and its checker.
package tcse_pkg;

   // connection states
   typedef enum logic [2:0] {
      ST_CLOSED     = 3'd0,
      ST_LISTEN     = 3'd1,
      ST_SYN_SENT   = 3'd2,
      ST_SYN_RCVD   = 3'd3,
      ST_ESTAB      = 3'd4,
      ST_FIN_WAIT1  = 3'd5,
      ST_FIN_WAIT2  = 3'd6,
      ST_CLOSE_WAIT = 3'd7
   } conn_state_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FREE,
      S_LOAD,
      S_EXEC,
      S_OUT0,
      S_OUT1
   } fsm_type;

   // operations
   localparam logic [2:0] OP_SEGMENT = 3'd0;
   localparam logic [2:0] OP_LISTEN  = 3'd1;
   localparam logic [2:0] OP_CONNECT = 3'd2;
   localparam logic [2:0] OP_CLOSE   = 3'd3;
   localparam logic [2:0] OP_SEND    = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_SEGMENT = 2'd1;
   localparam logic [1:0] KIND_DELIVER = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NOT_EST   = 2'd2;
   localparam logic [1:0] STAT_NO_MATCH  = 2'd3;

   // TCP flags
   localparam logic [7:0] FLAG_FIN = 8'h01;
   localparam logic [7:0] FLAG_SYN = 8'h02;
   localparam logic [7:0] FLAG_RST = 8'h04;
   localparam logic [7:0] FLAG_PSH = 8'h08;
   localparam logic [7:0] FLAG_ACK = 8'h10;

   // control registers
   localparam logic [1:0] CSR_HOST_IP    = 2'd0;
   localparam logic [1:0] CSR_INIT_SEQ   = 2'd1;
   localparam logic [1:0] CSR_FIRST_PORT = 2'd2;

   localparam logic [31:0] INIT_SEQ_RESET   = 32'hBEEFCAFE;
   localparam logic [15:0] FIRST_PORT_RESET = 16'd1024;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] remote_ip;
      logic [31:0] dest_ip;
      logic [15:0] remote_port;
      logic [15:0] local_port;
      logic [31:0] seq_in;
      logic [31:0] ack_in;
      logic [7:0]  flags_in;
      logic [15:0] payload_length;
      logic        payload_accepted;
      logic [3:0]  socket_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [3:0]  socket_out;
      logic [7:0]  flags_out;
      logic [31:0] out_local_ip;
      logic [31:0] out_remote_ip;
      logic [15:0] out_local_port;
      logic [15:0] out_remote_port;
      logic [31:0] seq_out;
      logic [31:0] ack_out;
      logic [15:0] data_length;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [31:0] value;
   } csr_type;

   // one connection table entry
   typedef struct packed {
      conn_state_type state;
      logic [15:0]    local_port;
      logic [15:0]    remote_port;
      logic [31:0]    local_ip;
      logic [31:0]    remote_ip;
      logic [31:0]    send_seq;
      logic [31:0]    exp_seq;
   } entry_type;

endpackage

// ----- rtl/core/tcse_chan_if.sv -----
// Valid/ready channel carrying one payload type.
// Payload types come from tcse_pkg at the point of instantiation.
interface tcse_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/tcp_connection_state_engine.sv -----
// TCP connection state engine: connection table in a synchronous memory plus sequencer.
// Depends on tcse_pkg and tcse_chan_if.
//
//  channel | dir | payload   | transaction
//  req_bus | in  | req_type  | one segment header or host command
//  rsp_bus | out | rsp_type  | one result, 1 or 2 per request, last marks the final one
//  csr_bus | in  | csr_type  | register write, always ready
//
// One request at a time. A received segment scans the table one entry per cycle
// through the memory read port. Listen and connect walk the valid bits for the lowest
// free slot; close and send read one entry when the slot is valid. Reset is
// synchronous and clears all slots at once through the valid bits. A stalled result
// holds its register.
module tcp_connection_state_engine #(
   parameter int SOCKETS = 16
) (
   input logic        clock,
   input logic        reset,
   tcse_chan_if.sink   req_bus,
   tcse_chan_if.source rsp_bus,
   tcse_chan_if.sink   csr_bus
);
   import tcse_pkg::*;

   localparam int SW = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;

   // control
   fsm_type            state_ff, state_in;
   logic [SOCKETS-1:0] valid_ff, valid_in;
   logic [SW:0]        scan_ff, scan_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [SW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic               two_ff, two_in;
   logic [31:0]        host_ip_ff, host_ip_in;
   logic [31:0]        iss_ff, iss_in;
   logic [15:0]        next_port_ff, next_port_in;

   // payload
   req_type            req_ff, req_in;
   entry_type          ent_ff, ent_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic               found_ff, found_in;
   rsp_type            res0_ff, res0_in, res1_ff, res1_in;

   // memory
   entry_type          conn_mem [SOCKETS];
   entry_type          rd_data_ff;
   logic               rd_en;
   logic [SW-1:0]      rd_addr;
   logic               mem_we;
   entry_type          mem_wd;

   // execute scratch
   entry_type          ne;
   logic [2:0]         fsa;
   logic               do_rst, do_data, issue, hit;
   logic [1:0]         nres;
   logic               idx_ok;

   localparam logic [2:0] FSA_SYN     = 3'b010;
   localparam logic [2:0] FSA_SYN_ACK = 3'b110;
   localparam logic [2:0] FSA_SYN_FIN = 3'b011;
   localparam logic [2:0] FSA_ALL     = 3'b111;
   localparam logic [2:0] FSA_FIN     = 3'b001;
   localparam logic [2:0] FSA_FIN_ACK = 3'b101;
   localparam logic [2:0] FSA_ACK     = 3'b100;

   function automatic rsp_type stat_rsp(logic [1:0] st, logic [3:0] sock);
      rsp_type r;
      r = '0;
      r.kind = KIND_STATUS;
      r.status = st;
      r.socket_out = sock;
      return r;
   endfunction

   function automatic rsp_type seg_rsp(entry_type e, logic [7:0] fl, logic [15:0] len,
                                       logic [SW-1:0] s);
      rsp_type r;
      r.kind = KIND_SEGMENT;
      r.status = STAT_OK;
      r.socket_out = 4'(s);
      r.flags_out = fl;
      r.out_local_ip = e.local_ip;
      r.out_remote_ip = e.remote_ip;
      r.out_local_port = e.local_port;
      r.out_remote_port = e.remote_port;
      r.seq_out = e.send_seq;
      r.ack_out = e.exp_seq;
      r.data_length = len;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic logic entry_match(entry_type e, req_type q);
      logic lsn, tup;
      lsn = (e.state == ST_LISTEN) && q.flags_in[1] && !q.flags_in[4];
      tup = (e.remote_port == q.remote_port) && (e.remote_ip == q.remote_ip);
      return (e.local_port == q.local_port) && (e.local_ip == q.dest_ip) && (lsn || tup);
   endfunction

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = (state_ff == S_OUT0) || (state_ff == S_OUT1);
   assign rsp_bus.data  = (state_ff == S_OUT1) ? res1_ff : res0_ff;

   assign idx_ok = (32'(req_bus.data.socket_index) < 32'(SOCKETS)) &&
                   valid_ff[SW'(req_bus.data.socket_index)];
   assign issue  = (scan_ff < (SW+1)'(SOCKETS));
   assign hit    = cmp_vld_ff && valid_ff[cmp_idx_ff] && entry_match(rd_data_ff, req_ff);
   assign fsa    = {req_ff.flags_in[4], req_ff.flags_in[1], req_ff.flags_in[0]};

   // sequencer, table update and result build
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      two_in       = two_ff;
      host_ip_in   = host_ip_ff;
      iss_in       = iss_ff;
      next_port_in = next_port_ff;
      req_in       = req_ff;
      ent_in       = ent_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      res0_in      = res0_ff;
      res1_in      = res1_ff;
      rd_en        = 1'b0;
      rd_addr      = scan_ff[SW-1:0];
      mem_we       = 1'b0;
      ne           = ent_ff;
      do_rst       = 1'b0;
      do_data      = 1'b0;
      nres         = 2'd0;

      // register writes
      if (csr_bus.valid) begin
         unique case (csr_bus.data.index)
            CSR_HOST_IP:    host_ip_in = csr_bus.data.value;
            CSR_INIT_SEQ:   iss_in = csr_bus.data.value;
            CSR_FIRST_PORT: next_port_in = csr_bus.data.value[15:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               req_in     = req_bus.data;
               scan_in    = '0;
               found_in   = 1'b0;
               slot_in    = SW'(req_bus.data.socket_index);
               unique case (req_bus.data.operation)
                  OP_SEGMENT: state_in = S_SCAN;
                  OP_LISTEN, OP_CONNECT: state_in = S_FREE;
                  OP_CLOSE, OP_SEND: begin
                     rd_en   = idx_ok;
                     rd_addr = SW'(req_bus.data.socket_index);
                     found_in = idx_ok;
                     state_in = idx_ok ? S_LOAD : S_EXEC;
                  end
                  default: state_in = S_EXEC;
               endcase
            end
         end
         S_SCAN: begin
            // issue one read per cycle, compare the previous one
            rd_en      = issue;
            cmp_vld_in = issue;
            cmp_idx_in = scan_ff[SW-1:0];
            if (issue) scan_in = scan_ff + 1'b1;
            if (hit) begin
               ent_in   = rd_data_ff;
               slot_in  = cmp_idx_ff;
               found_in = 1'b1;
               state_in = S_EXEC;
            end else if (!issue && !cmp_vld_ff) begin
               state_in = S_EXEC;
            end
         end
         S_FREE: begin
            if (!issue) begin
               state_in = S_EXEC;
            end else if (!valid_ff[scan_ff[SW-1:0]]) begin
               slot_in  = scan_ff[SW-1:0];
               found_in = 1'b1;
               state_in = S_EXEC;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_LOAD: begin
            ent_in   = rd_data_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            res0_in = stat_rsp(STAT_OK, 4'(slot_ff));
            res1_in = res0_in;
            case (req_ff.operation)
               OP_SEGMENT: begin
                  if (!found_ff) begin
                     if (req_ff.flags_in[2]) begin
                        res0_in = stat_rsp(STAT_NO_MATCH, 4'd0);
                     end else begin
                        res0_in.kind = KIND_SEGMENT;
                        res0_in.status = STAT_NO_MATCH;
                        res0_in.socket_out = 4'd0;
                        res0_in.flags_out = FLAG_RST;
                        res0_in.out_local_ip = req_ff.dest_ip;
                        res0_in.out_remote_ip = req_ff.remote_ip;
                        res0_in.out_local_port = req_ff.local_port;
                        res0_in.out_remote_port = req_ff.remote_port;
                        res0_in.seq_out = req_ff.ack_in;
                        res0_in.ack_out = req_ff.seq_in + 32'd1;
                     end
                     nres = 2'd1;
                  end else begin
                     mem_we = 1'b1;
                     if (req_ff.flags_in[2]) ne.state = ST_CLOSED;
                     if (ne.state != ST_CLOSED) begin
                        case (fsa)
                           FSA_SYN: begin
                              if (ent_ff.state == ST_LISTEN) begin
                                 ne.state = ST_SYN_RCVD;
                                 ne.remote_port = req_ff.remote_port;
                                 ne.remote_ip = req_ff.remote_ip;
                                 ne.exp_seq = req_ff.seq_in + 32'd1;
                                 ne.send_seq = iss_ff;
                                 res0_in = seg_rsp(ne, FLAG_SYN | FLAG_ACK, 16'd0, slot_ff);
                                 ne.send_seq = iss_ff + 32'd1;
                                 nres = 2'd1;
                              end else do_rst = 1'b1;
                           end
                           FSA_SYN_ACK: begin
                              if (ent_ff.state == ST_SYN_SENT) begin
                                 ne.state = ST_ESTAB;
                                 ne.exp_seq = req_ff.seq_in + 32'd1;
                                 ne.send_seq = ent_ff.send_seq + 32'd1;
                                 res0_in = seg_rsp(ne, FLAG_ACK, 16'd0, slot_ff);
                                 nres = 2'd1;
                              end else do_rst = 1'b1;
                           end
                           FSA_SYN_FIN, FSA_ALL: do_rst = 1'b1;
                           FSA_FIN, FSA_FIN_ACK: begin
                              if (ent_ff.state == ST_ESTAB) begin
                                 ne.state = ST_CLOSE_WAIT;
                                 ne.exp_seq = ent_ff.exp_seq + 32'd1;
                                 res0_in = seg_rsp(ne, FLAG_ACK, 16'd0, slot_ff);
                                 res1_in = seg_rsp(ne, FLAG_FIN | FLAG_ACK, 16'd0, slot_ff);
                                 ne.send_seq = ent_ff.send_seq + 32'd1;
                                 nres = 2'd2;
                              end else if (ent_ff.state == ST_CLOSE_WAIT) begin
                                 ne.state = ST_CLOSED;
                              end else if (ent_ff.state == ST_FIN_WAIT1 ||
                                           ent_ff.state == ST_FIN_WAIT2) begin
                                 ne.state = ST_CLOSED;
                                 ne.exp_seq = ent_ff.exp_seq + 32'd1;
                                 res0_in = seg_rsp(ne, FLAG_ACK, 16'd0, slot_ff);
                                 nres = 2'd1;
                              end else do_rst = 1'b1;
                           end
                           FSA_ACK: begin
                              if (ent_ff.state == ST_SYN_RCVD) ne.state = ST_ESTAB;
                              else if (ent_ff.state == ST_FIN_WAIT1) ne.state = ST_FIN_WAIT2;
                              else if (ent_ff.state == ST_CLOSE_WAIT) ne.state = ST_CLOSED;
                              else if (req_ff.flags_in != FLAG_ACK) do_data = 1'b1;
                           end
                           default: do_data = 1'b1;
                        endcase
                     end
                     // in-order payload delivery
                     if (do_data) begin
                        if (req_ff.seq_in == ent_ff.exp_seq && req_ff.payload_accepted) begin
                           ne.exp_seq = ent_ff.exp_seq + 32'(req_ff.payload_length);
                           res0_in = '0;
                           res0_in.kind = KIND_DELIVER;
                           res0_in.socket_out = 4'(slot_ff);
                           res0_in.data_length = req_ff.payload_length;
                           res1_in = seg_rsp(ne, FLAG_ACK, 16'd0, slot_ff);
                           nres = 2'd2;
                        end else do_rst = 1'b1;
                     end
                     if (do_rst) begin
                        res0_in = seg_rsp(ne, FLAG_RST, 16'd0, slot_ff);
                        nres = 2'd1;
                     end
                     if (ne.state == ST_CLOSED) valid_in[slot_ff] = 1'b0;
                     if (nres == 2'd0) nres = 2'd1;
                  end
               end
               OP_LISTEN, OP_CONNECT: begin
                  nres = 2'd1;
                  if (!found_ff) begin
                     res0_in = stat_rsp(STAT_FULL, 4'd0);
                  end else begin
                     mem_we = 1'b1;
                     valid_in[slot_ff] = 1'b1;
                     ne.local_ip = host_ip_ff;
                     ne.send_seq = iss_ff;
                     ne.exp_seq = '0;
                     if (req_ff.operation == OP_LISTEN) begin
                        ne.state = ST_LISTEN;
                        ne.local_port = req_ff.local_port;
                        ne.remote_port = '0;
                        ne.remote_ip = '0;
                     end else begin
                        ne.state = ST_SYN_SENT;
                        ne.local_port = next_port_ff;
                        ne.remote_port = req_ff.remote_port;
                        ne.remote_ip = req_ff.remote_ip;
                        next_port_in = next_port_ff + 16'd1;
                        res0_in = seg_rsp(ne, FLAG_SYN, 16'd0, slot_ff);
                     end
                  end
               end
               OP_CLOSE, OP_SEND: begin
                  nres = 2'd1;
                  if (!found_ff) begin
                     res0_in = stat_rsp(STAT_NO_MATCH, req_ff.socket_index);
                  end else if (req_ff.operation == OP_CLOSE) begin
                     if (ent_ff.state == ST_LISTEN) begin
                        valid_in[slot_ff] = 1'b0;
                     end else begin
                        mem_we = 1'b1;
                        ne.state = ST_FIN_WAIT1;
                        res0_in = seg_rsp(ne, FLAG_FIN | FLAG_ACK, 16'd0, slot_ff);
                        ne.send_seq = ent_ff.send_seq + 32'd1;
                     end
                  end else if (ent_ff.state != ST_ESTAB) begin
                     res0_in = stat_rsp(STAT_NOT_EST, req_ff.socket_index);
                  end else begin
                     mem_we = 1'b1;
                     res0_in = seg_rsp(ne, FLAG_PSH | FLAG_ACK, req_ff.payload_length,
                                       slot_ff);
                     ne.send_seq = ent_ff.send_seq + 32'(req_ff.payload_length);
                  end
               end
               default: begin
                  res0_in = stat_rsp(STAT_OK, 4'd0);
                  nres = 2'd1;
               end
            endcase
            two_in = (nres == 2'd2);
            if (nres == 2'd2) res1_in.last = 1'b1;
            else res0_in.last = 1'b1;
            state_in = S_OUT0;
         end
         S_OUT0: begin
            if (rsp_bus.ready) state_in = two_ff ? S_OUT1 : S_IDLE;
         end
         S_OUT1: begin
            if (rsp_bus.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign mem_wd = ne;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         scan_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         two_ff       <= 1'b0;
         host_ip_ff   <= '0;
         iss_ff       <= INIT_SEQ_RESET;
         next_port_ff <= FIRST_PORT_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         scan_ff      <= scan_in;
         cmp_vld_ff   <= cmp_vld_in;
         two_ff       <= two_in;
         host_ip_ff   <= host_ip_in;
         iss_ff       <= iss_in;
         next_port_ff <= next_port_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      ent_ff     <= ent_in;
      slot_ff    <= slot_in;
      found_ff   <= found_in;
      cmp_idx_ff <= cmp_idx_in;
      res0_ff    <= res0_in;
      res1_ff    <= res1_in;
   end

   // connection table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) conn_mem[slot_ff] <= mem_wd;
      if (rd_en) rd_data_ff <= conn_mem[rd_addr];
   end

endmodule

// ----- rtl/core/tcse_checker.sv -----
// Port-level checks for the TCP connection state engine, bound to the top level.
// Depends on tcse_pkg, tcse_chan_if and the assertion macro header.
`include "tcp_connection_state_engine_assert.svh"

module tcse_checker (
   input logic         clock,
   input logic         reset,
   tcse_chan_if.sink   req_bus,
   tcse_chan_if.source rsp_bus
);
   import tcse_pkg::*;

   `TCSE_ASSERT_NEXT(a_rsp_hold, rsp_bus.valid && !rsp_bus.ready,
      rsp_bus.valid && $stable(rsp_bus.data), "result changed while stalled")
   `TCSE_ASSERT_NEXT(a_one_at_a_time, req_bus.valid && req_bus.ready, !req_bus.ready,
      "request taken while another is in flight")
   `TCSE_ASSERT_NOW(a_deliver_not_last, rsp_bus.valid && rsp_bus.data.kind == KIND_DELIVER,
      !rsp_bus.data.last, "delivery not followed by its ACK")
   `TCSE_ASSERT_NOW(a_status_clean, rsp_bus.valid && rsp_bus.data.kind == KIND_STATUS,
      rsp_bus.data.flags_out == 8'd0 && rsp_bus.data.seq_out == 32'd0,
      "status result carries segment fields")
endmodule

bind tcp_connection_state_engine tcse_checker u_tcse_checker (
   .clock(clock),
   .reset(reset),
   .req_bus(req_bus),
   .rsp_bus(rsp_bus)
);
